// File: hdl/aes_pkg.sv
// Package for the AES CBC encryptor: codes, S-box and round functions.
// No dependencies.
package aes_pkg;

    localparam int unsigned KeyWords = 30;

    typedef enum logic [1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_ENCRYPT = 2'd1,
        FUNC_RESTART = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        REG_KEY_LENGTH = 2'd0,
        REG_IV_HIGH    = 2'd1,
        REG_IV_LOW     = 2'd2,
        REG_NONE       = 2'd3
    } reg_idx_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of the state sits at bits [127-8i -: 8]
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (r + 4 * c) -: 8] =
                    sbox(s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]);
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3, all;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32 * c -: 8];
            a1 = s[119 - 32 * c -: 8];
            a2 = s[111 - 32 * c -: 8];
            a3 = s[103 - 32 * c -: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            t[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            t[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            t[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

endpackage

// File: hdl/aes_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module aes_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hdl/aes_round.sv
// One AES round datapath: SubBytes/ShiftRows, optional MixColumns, AddRoundKey.
// Depends on aes_pkg.
module aes_round (
    input  logic [127:0] state_in,
    input  logic [127:0] round_key,
    input  logic         initial_rnd,
    input  logic         final_rnd,
    output logic [127:0] state_out
);
    logic [127:0] ss;
    logic [127:0] mc;

    always_comb begin
        ss = aes_pkg::sub_shift(state_in);
        mc = aes_pkg::mix_columns(ss);
        if (initial_rnd) begin
            state_out = state_in ^ round_key;
        end else if (final_rnd) begin
            state_out = ss ^ round_key;
        end else begin
            state_out = mc ^ round_key;
        end
    end
endmodule

// File: hdl/aes_cbc_encrypt.sv
// AES CBC encryptor top level: control sequencer, key store, chaining state.
// Depends on aes_pkg, aes_ram, aes_round.
// Load/restart items are handled in the idle state. An encrypt item passes through
// a fetch state, then the run state with two key store reads per round (high word,
// then low word, through one 64-bit read port), then the output state. A new item
// is accepted only after the previous encrypt item has left the output state.
// The result waits in an output register; only a second finished block stalls.
// Reset (aresetn low, synchronous) clears chain, registers and control; the
// key store is not cleared and must be loaded before use.
module aes_cbc_encrypt (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write port
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata: word_index[4:0], word_value[68:5], block_high[132:69],
    //          block_low[196:133], zero fill to 199
    input  logic [199:0] s_tdata,
    input  logic [1:0]   s_tuser,   // func[1:0]
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // cipher_high[63:0], cipher_low[127:64]
);
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    logic [1:0]    key_length_reg;
    logic [63:0]   iv_high_reg, iv_low_reg;
    logic [127:0]  chain_reg, chain_next;
    logic [127:0]  blk_reg, blk_next;
    logic [3:0]    rnd_reg, rnd_next;      // round currently being applied
    logic [4:0]    rd_addr_reg, rd_addr_next;
    logic          half_reg, half_next;    // 0: high key word, 1: low
    logic [63:0]   khi_reg, khi_next;
    logic [127:0]  out_reg, out_next;
    logic          m_valid_reg, m_valid_next;

    logic [1:0]    func;
    logic [4:0]    word_index;
    logic [63:0]   rdata;
    logic          accept;
    logic [3:0]    rounds;
    logic [127:0]  round_out;
    logic          ram_we;

    assign func       = s_tuser;
    assign word_index = s_tdata[4:0];
    assign accept     = s_tvalid && s_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {out_reg[63:0], out_reg[127:64]};
    assign ram_we     = accept && (func == aes_pkg::FUNC_LOAD)
                        && (word_index < 5'(aes_pkg::KeyWords));

    always_comb begin
        unique case (key_length_reg)
            2'd0:    rounds = 4'd10;
            2'd1:    rounds = 4'd12;
            default: rounds = 4'd14;
        endcase
    end

    // key store; read address is stepped one word per cycle through a block's round keys
    aes_ram #(.WIDTH(64), .DEPTH(32)) u_key_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (word_index),
        .wdata (s_tdata[68:5]),
        .raddr (rd_addr_reg),
        .rdata (rdata)
    );

    aes_round u_round (
        .state_in    (blk_reg),
        .round_key   ({khi_reg, rdata}),
        .initial_rnd (rnd_reg == 4'd0),
        .final_rnd   (rnd_reg == rounds),
        .state_out   (round_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_length_reg <= '0;
            iv_high_reg    <= '0;
            iv_low_reg     <= '0;
        end else if (cfg_we) begin
            unique case (aes_pkg::reg_idx_t'(cfg_index))
                aes_pkg::REG_KEY_LENGTH: key_length_reg <= cfg_data[1:0];
                aes_pkg::REG_IV_HIGH:    iv_high_reg    <= cfg_data;
                aes_pkg::REG_IV_LOW:     iv_low_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Each round reads the high key word, then the low word and applies the round.
    always_comb begin
        state_next   = state_reg;
        chain_next   = chain_reg;
        blk_next     = blk_reg;
        rnd_next     = rnd_reg;
        rd_addr_next = rd_addr_reg;
        half_next    = half_reg;
        khi_next     = khi_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (func == aes_pkg::FUNC_RESTART) begin
                        chain_next = {iv_high_reg, iv_low_reg};
                    end else if (func == aes_pkg::FUNC_ENCRYPT) begin
                        blk_next     = {s_tdata[132:69], s_tdata[196:133]} ^ chain_reg;
                        rnd_next     = 4'd0;
                        rd_addr_next = 5'd0;
                        half_next    = 1'b0;
                        state_next   = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                // high word address presented; next cycle its data arrives
                rd_addr_next = rd_addr_reg + 5'd1;
                state_next   = ST_RUN;
            end
            ST_RUN: begin
                if (!half_reg) begin
                    khi_next     = rdata;
                    half_next    = 1'b1;
                    rd_addr_next = rd_addr_reg + 5'd1;
                end else begin
                    blk_next  = round_out;
                    half_next = 1'b0;
                    if (rnd_reg == rounds) begin
                        state_next = ST_OUT;
                    end else begin
                        rnd_next     = rnd_reg + 4'd1;
                        rd_addr_next = rd_addr_reg + 5'd1;
                        khi_next     = khi_reg;
                        // next round's high word is being read this cycle
                        state_next   = ST_RUN;
                    end
                end
            end
            ST_OUT: begin
                // hold while an earlier result still waits in the output register
                if (!m_valid_reg || m_tready) begin
                    chain_next   = blk_reg;
                    out_next     = blk_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            chain_reg   <= '0;
            m_valid_reg <= 1'b0;
            rnd_reg     <= '0;
            half_reg    <= 1'b0;
            rd_addr_reg <= '0;
        end else begin
            state_reg   <= state_next;
            chain_reg   <= chain_next;
            m_valid_reg <= m_valid_next;
            rnd_reg     <= rnd_next;
            half_reg    <= half_next;
            rd_addr_reg <= rd_addr_next;
        end
        blk_reg <= blk_next;
        khi_reg <= khi_next;
        out_reg <= out_next;
    end
endmodule
